### src/pfa_pkg.sv
// Shared types and constants of the page-frame allocator.
`default_nettype none

package pfa_pkg;

	localparam int FRAME_W    = 12;
	localparam int COUNT_W    = 13;
	localparam int MAX_FRAMES = 4096;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd4096;

	typedef enum logic [1:0] {
		CMD_CLAIM = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2
	} pfa_cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_RANGE  = 2'd1,
		ERR_DOUBLE = 2'd2,
		ERR_EMPTY  = 2'd3
	} pfa_err_t;

endpackage

`default_nettype wire

### src/page_frame_free_list_allocator_core.sv
// Page-frame allocator core: linked free list in a next-frame memory with a free bitmap.
`default_nettype none

// Usage
// Requests arrive on the input channel (in_valid, in_stall, cmd, frame_in) and are taken
// at an edge with in_valid high and in_stall low. Each request gives exactly one response
// on the output channel (out_valid, out_stall, frame_out, granted, error_code, free_count).
// A request is accepted and its memory reads are registered; the response is registered
// once the read data are in and the output register is free. in_stall stays high while
// a request waits for its result, so a new request is accepted only after the previous
// one has read the next-frame memory and free bitmap and done its update and write-back.
// The register limit_q is written through cfg_valid, cfg_ready and cfg_data; the port
// is always ready and must only be written while no request is outstanding.
// After reset the free bitmap is cleared one entry per cycle, over min(FRAMES, 4096)
// entries; in_stall is held high during that pass.
// When the receiver stalls, the response stays in the output register and one further
// request may be accepted; it waits with its read data until the output register frees.

module page_frame_free_list_allocator_core
	import pfa_pkg::*;
#(
	parameter int FRAMES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [FRAME_W-1:0] frame_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FRAME_W-1:0]      frame_out,
	output logic                    granted,
	output logic [1:0]              error_code,
	output logic [COUNT_W-1:0]      free_count,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data
);

	localparam int DEPTH = (FRAMES < MAX_FRAMES) ? FRAMES : MAX_FRAMES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [AW-1:0] next_mem [DEPTH];
	logic          free_mem [DEPTH];

	logic [AW-1:0]      next_rd_q;
	logic               free_rd_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic [COUNT_W-1:0] limit_q;
	logic               clearing_q;
	logic [AW-1:0]      clr_q;

	logic               s1_valid_q;
	logic [1:0]         cmd_s1;
	logic [FRAME_W-1:0] frame_s1;

	logic               out_valid_q;
	logic [FRAME_W-1:0] fout_q;
	logic               grant_q;
	pfa_err_t           err_q;
	logic [CW-1:0]      cnt_out_q;

	logic          accept;
	logic          done;
	logic [AW-1:0] f_idx;
	logic          range_bad;
	pfa_err_t      err_w;
	logic          grant_w;
	logic [AW-1:0] fout_w;
	logic [AW-1:0] head_n;
	logic [AW-1:0] tail_n;
	logic [CW-1:0] count_n;
	logic          nt_we;
	logic [AW-1:0] nt_addr;
	logic [AW-1:0] nt_data;
	logic          fm_we;
	logic [AW-1:0] fm_addr;
	logic          fm_data;

	assign in_stall   = clearing_q || s1_valid_q;
	assign accept     = in_valid && !in_stall;
	assign done       = s1_valid_q && (!out_valid_q || !out_stall);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign frame_out  = fout_q;
	assign granted    = grant_q;
	assign error_code = err_q;
	assign free_count = COUNT_W'(cnt_out_q);

	assign f_idx     = frame_s1[AW-1:0];
	assign range_bad = ({1'b0, frame_s1} >= limit_q) || (32'(frame_s1) >= DEPTH);

	always_comb begin
		err_w   = ERR_NONE;
		grant_w = 1'b0;
		fout_w  = '0;
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		nt_we   = 1'b0;
		nt_addr = f_idx;
		nt_data = head_q;
		fm_we   = 1'b0;
		fm_addr = f_idx;
		fm_data = 1'b1;
		case (cmd_s1)
			CMD_CLAIM: begin
				if (range_bad) begin
					err_w = ERR_RANGE;
				end else if (free_rd_q) begin
					err_w = ERR_DOUBLE;
				end else begin
					grant_w = 1'b1;
					fm_we   = 1'b1;
					if (count_q == '0) begin
						head_n = f_idx;
					end else begin
						nt_we   = 1'b1;
						nt_addr = tail_q;
						nt_data = f_idx;
					end
					tail_n  = f_idx;
					count_n = CW'(count_q + 1'b1);
				end
			end
			CMD_ALLOC: begin
				if (count_q == '0) begin
					err_w = ERR_EMPTY;
				end else begin
					grant_w = 1'b1;
					fout_w  = head_q;
					head_n  = next_rd_q;
					fm_we   = 1'b1;
					fm_addr = head_q;
					fm_data = 1'b0;
					count_n = CW'(count_q - 1'b1);
				end
			end
			CMD_FREE: begin
				if (range_bad) begin
					err_w = ERR_RANGE;
				end else if (free_rd_q) begin
					err_w = ERR_DOUBLE;
				end else begin
					grant_w = 1'b1;
					fm_we   = 1'b1;
					nt_we   = 1'b1;
					if (count_q == '0) begin
						tail_n = f_idx;
					end
					head_n  = f_idx;
					count_n = CW'(count_q + 1'b1);
				end
			end
			default: begin
				err_w = ERR_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			next_rd_q <= next_mem[head_q];
			free_rd_q <= free_mem[frame_in[AW-1:0]];
		end
		if (done && nt_we) begin
			next_mem[nt_addr] <= nt_data;
		end
		if (clearing_q) begin
			free_mem[clr_q] <= 1'b0;
		end else if (done && fm_we) begin
			free_mem[fm_addr] <= fm_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			frame_s1 <= frame_in;
		end
		if (done) begin
			fout_q    <= FRAME_W'(fout_w);
			grant_q   <= grant_w;
			err_q     <= err_w;
			cnt_out_q <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
		end else begin
			if (clearing_q) begin
				clr_q <= AW'(clr_q + 1'b1);
				if (clr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
				head_q      <= head_n;
				tail_q      <= tail_n;
				count_q     <= count_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) 32'(count_q) <= DEPTH)
		else $error("Free count exceeds the number of frames.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && grant_q |-> err_q == ERR_NONE)
		else $error("Granted response carries an error code.");

	assert property (@(posedge clk) disable iff (!arst_n) done |=> out_valid_q)
		else $error("Completed request did not produce a response.");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && grant_w && cmd_s1 == CMD_ALLOC |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("Granted allocation did not lower the free count.");

endmodule

`default_nettype wire
